FILE: hdl/tasf_pkg.sv
// Package: types, constants and register codes for the trend-adaptive smoothing filter.
`timescale 1ns / 1ps
`default_nettype none
package tasf_pkg;

   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 16;
   localparam int COEF_W      = 16;
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int VALUE_W     = SAMPLE_BITS + FRAC_BITS;
   localparam int OUT_W       = 28;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_RESTART = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FLOOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CAP     = 2'd2;

   localparam logic [COEF_W-1:0] COEF_RESTART_RST = 16'd66;
   localparam logic [COEF_W-1:0] COEF_FLOOR_RST   = 16'd655;
   localparam logic [COEF_W-1:0] COEF_CAP_RST     = 16'd64881;

   typedef struct packed {
      logic [2:0]  channel;
      logic [11:0] sample;
   } req_word_type;

   typedef struct packed {
      logic [2:0]       channel_out;
      logic [OUT_W-1:0] filtered;
   } rsp_word_type;

   typedef struct packed {
      logic [COEF_W-1:0] coef_restart;
      logic [COEF_W-1:0] coef_floor;
      logic [COEF_W-1:0] coef_cap;
   } coef_cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0] filter_value;
      logic               trend_rising;
      logic [COEF_W-1:0]  coefficient;
   } chan_state_type;

endpackage
`default_nettype wire

FILE: hdl/tasf_csr.sv
// Configuration registers: restart, floor and cap coefficients.
`timescale 1ns / 1ps
`default_nettype none
module tasf_csr
   import tasf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_data,
   output coef_cfg_type              cfg
);

   coef_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COEF_RESTART: cfg_in.coef_restart = csr_data;
            CSR_COEF_FLOOR:   cfg_in.coef_floor   = csr_data;
            CSR_COEF_CAP:     cfg_in.coef_cap     = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_restart <= COEF_RESTART_RST;
         cfg_ff.coef_floor   <= COEF_FLOOR_RST;
         cfg_ff.coef_cap     <= COEF_CAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/tasf_state.sv
// Per-channel filter state: filtered value, trend bit and coefficient.
`timescale 1ns / 1ps
`default_nettype none
module tasf_state
   import tasf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [CH_W-1:0] rd_index,
   output chan_state_type       rd_entry,
   input  wire logic            wr_en,
   input  wire logic [CH_W-1:0] wr_index,
   input  chan_state_type       wr_entry
);

   chan_state_type state_ff [CHANNELS];

   always_comb begin
      if (32'(rd_index) < CHANNELS) begin
         rd_entry = state_ff[rd_index];
      end else begin
         rd_entry = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            state_ff[i] <= '0;
         end
      end else if (wr_en && (32'(wr_index) < CHANNELS)) begin
         state_ff[wr_index] <= wr_entry;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/tasf_update.sv
// Update datapath: trend, coefficient clamp and multiply-add of one word.
`timescale 1ns / 1ps
`default_nettype none
module tasf_update
   import tasf_pkg::*;
(
   input  req_word_type   word,
   input  chan_state_type cur,
   input  coef_cfg_type   cfg,
   output chan_state_type nxt,
   output logic           in_range,
   output rsp_word_type   result
);

   localparam int DELTA_W = VALUE_W + 1;
   localparam int CPROD_W = COEF_W + 2;
   localparam int PROD_W  = DELTA_W + CPROD_W;
   localparam int SUM_W   = VALUE_W + 2;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   logic [SAMPLE_BITS-1:0]   smp;
   logic signed [DELTA_W-1:0] delta;
   logic                      rising;
   logic [COEF_W:0]           c_raw, c_flr, c_fin, cap_ext;
   logic signed [PROD_W-1:0]  prod, step;
   logic signed [SUM_W-1:0]   sum;
   logic [VALUE_W-1:0]        nv;

   assign in_range = 32'(word.channel) < CHANNELS;
   assign smp      = SAMPLE_BITS'(word.sample);
   assign delta    = $signed({1'b0, smp, {FRAC_BITS{1'b0}}})
                   - $signed({1'b0, cur.filter_value});
   assign rising   = ~delta[DELTA_W-1];
   assign cap_ext  = {1'b0, cfg.coef_cap};

   always_comb begin
      if (rising == cur.trend_rising) begin
         c_raw = {cur.coefficient, 1'b0};
      end else begin
         c_raw = {1'b0, cfg.coef_restart};
      end
      c_flr = (c_raw == '0) ? {1'b0, cfg.coef_floor} : c_raw;
      c_fin = (c_flr > cap_ext) ? cap_ext : c_flr;
   end

   assign prod = PROD_W'(delta) * $signed(PROD_W'({1'b0, c_fin}));
   assign step = prod >>> FRAC_BITS;
   assign sum  = $signed({2'b00, cur.filter_value}) + step[SUM_W-1:0];

   always_comb begin
      if (sum[SUM_W-1]) begin
         nv = '0;
      end else if (sum[SUM_W-2]) begin
         nv = VALUE_MAX;
      end else begin
         nv = sum[VALUE_W-1:0];
      end
   end

   assign nxt.filter_value = nv;
   assign nxt.trend_rising = rising;
   assign nxt.coefficient  = c_fin[COEF_W-1:0];

   assign result.channel_out = word.channel;
   assign result.filtered    = in_range ? OUT_W'(nv) : '0;

endmodule
`default_nettype wire

FILE: hdl/trend_adaptive_smoothing_filter_core.sv
// Top level of the trend-adaptive smoothing filter: input and result registers.
//
//   channel  direction  handshake          word
//   req      in         req_valid/stall    req_word_type {channel, sample}
//   rsp      out        rsp_valid/stall    rsp_word_type {channel_out, filtered}
//   csr      in         csr_valid/ready    csr_index, csr_data (always ready)
//
// One word per cycle unless rsp_stall holds; an accepted word enters the input register,
// then a multiply-add read-modify-write of the channel state fills the result register.
// Synchronous reset clears both stages and the channel state; coefficients take defaults.
// rsp_stall holds the result register; the input register takes one more word.
`timescale 1ns / 1ps
`default_nettype none
module trend_adaptive_smoothing_filter_core
   import tasf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_word_type              rsp_word,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_data
);

   coef_cfg_type   cfg;
   chan_state_type cur_entry, nxt_entry;
   rsp_word_type   result;
   logic           in_range;
   logic           advance;
   logic           s1_load;

   logic           s1_valid_ff, s1_valid_in;
   req_word_type   s1_word_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_word_type   out_word_ff;

   tasf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tasf_state u_state (
      .clock    (clock),
      .reset    (reset),
      .rd_index (s1_word_ff.channel[CH_W-1:0]),
      .rd_entry (cur_entry),
      .wr_en    (s1_valid_ff && advance && in_range),
      .wr_index (s1_word_ff.channel[CH_W-1:0]),
      .wr_entry (nxt_entry)
   );

   tasf_update u_update (
      .word     (s1_word_ff),
      .cur      (cur_entry),
      .cfg      (cfg),
      .nxt      (nxt_entry),
      .in_range (in_range),
      .result   (result)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || advance;
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
      end
      if (s1_load) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_word_ff <= req_word;
      end
      if (advance && s1_valid_ff) begin
         out_word_ff <= result;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && out_valid_ff)
      else $error("input stalled with a free pipeline");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid)
      else $error("advancing word lost");

   a_idle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_word.channel_out) >= CHANNELS) |-> rsp_word.filtered == '0)
      else $error("unused channel returned a nonzero value");

endmodule
`default_nettype wire
